/* rtl/core/lpcm_pkg.sv */
package lpcm_pkg;

  localparam int unsigned FracShift = 7;
  localparam logic [31:0] FlagsReset = 32'd12;
  localparam logic [7:0] BitsReset = 8'd16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CFG_FLAGS = 1'b0,
    CFG_BITS  = 1'b1
  } cfg_index_t;

  // Completed sample as the front hands it to the back.
  typedef struct packed {
    logic        is_sample;  // 0: end-of-buffer marker only
    logic        last;
    logic        wide;       // 4-byte sample
    logic        is_float;
    logic [5:0]  frac;
    logic [31:0] raw;
  } lpcm_job_t;

  function automatic logic [15:0] f32_peak(input logic [31:0] w);
    logic [7:0]  e;
    logic [23:0] m;
    logic [31:0] v;
    begin
      e = w[30:23];
      m = {1'b1, w[22:0]};
      v = '0;
      // |x|*32768 = m * 2^(e-127+15-23) = m >> (135-e)
      if (e >= 8'd127) begin
        v = 32'd32768;
      end else if (e >= 8'd112) begin
        v = {8'd0, m} >> (8'd135 - e);
      end
      return v[15:0];
    end
  endfunction

endpackage

/* rtl/core/lpcm_front.sv */
module lpcm_front
  import lpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] lpcm_flags,
  input  logic [7:0]  sample_bits,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        job_valid,
  input  logic        job_ready,
  output lpcm_job_t   job
);

  logic [1:0]  byte_position;
  logic [23:0] partial_word;
  logic [5:0]  frac;
  logic        fmt_ok, wide, done, fire;

  assign frac = lpcm_flags[FracShift +: 6];
  assign wide = (sample_bits == 8'd32);

  always_comb begin
    fmt_ok = 1'b0;
    if (!lpcm_flags[1] && !lpcm_flags[4] && lpcm_flags[3]) begin
      if (lpcm_flags[0]) begin
        fmt_ok = wide && (frac == 6'd0);
      end else if (sample_bits == 8'd16) begin
        fmt_ok = lpcm_flags[2] && (frac < 6'd16);
      end else if (wide) begin
        fmt_ok = lpcm_flags[2] && (frac < 6'd32);
      end
    end
  end

  assign done = fmt_ok && ({1'b0, byte_position} + 3'd1 >= (wide ? 3'd4 : 3'd2));
  assign in_ready = job_ready;
  assign fire = in_valid && in_ready;
  assign job_valid = in_valid && (done || last_byte);

  always_comb begin
    job.is_sample = done;
    job.last = last_byte;
    job.wide = wide;
    job.is_float = lpcm_flags[0];
    job.frac = frac;
    job.raw = wide ? {data_byte, partial_word} : {16'd0, data_byte, partial_word[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      partial_word <= '0;
    end else if (fire) begin
      if (!fmt_ok || done || last_byte) begin
        byte_position <= '0;
        partial_word <= '0;
      end else begin
        byte_position <= byte_position + 2'd1;
        unique case (byte_position)
          2'd0: partial_word[7:0] <= data_byte;
          2'd1: partial_word[15:8] <= data_byte;
          2'd2: partial_word[23:16] <= data_byte;
          default: partial_word <= partial_word;
        endcase
      end
    end
  end

endmodule

/* rtl/core/lpcm_queue.sv */
module lpcm_queue
  import lpcm_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  lpcm_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output lpcm_job_t rd_data
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  lpcm_job_t       slots [Depth];
  logic [Aw-1:0]   wr_ptr, rd_ptr;
  logic [Aw:0]     count;
  logic            push, pop;

  assign wr_ready = (count != (Aw+1)'(Depth)) || rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data = slots[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

/* rtl/core/lpcm_back.sv */
module lpcm_back
  import lpcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  lpcm_job_t   job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sample_valid,
  output logic [31:0] sample_word,
  output logic [15:0] peak_level,
  output logic        end_of_buffer
);

  // Stage 1: sign/magnitude and leading-one position.
  logic        s1_valid, s1_sample, s1_last, s1_float, s1_wide;
  logic [5:0]  s1_frac;
  logic [31:0] s1_raw, s1_mag;
  logic        s1_sign;
  logic [4:0]  s1_msb;
  // Stage 2: decoded word and its peak.
  logic        s2_valid, s2_sample, s2_last;
  logic [31:0] s2_word;
  logic [15:0] s2_pk;
  // Output register.
  logic        o_valid;
  logic [15:0] running_peak;

  logic        adv2, adv1, adv0;
  logic [31:0] sx, mag_c;
  logic [4:0]  msb_c;

  assign adv2 = !o_valid || out_ready;
  assign adv1 = !s2_valid || adv2;
  assign adv0 = !s1_valid || adv1;
  assign job_ready = adv0;

  always_comb begin
    sx = job.wide ? job.raw : {{16{job.raw[15]}}, job.raw[15:0]};
    mag_c = sx[31] ? (32'd0 - sx) : sx;
    msb_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag_c[i]) msb_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv0) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_sample <= job.is_sample;
      s1_last <= job.last;
      s1_float <= job.is_float;
      s1_wide <= job.wide;
      s1_frac <= job.frac;
      s1_raw <= job.raw;
      s1_sign <= sx[31];
      s1_mag <= mag_c;
      s1_msb <= msb_c;
    end
  end

  // Stage 2 combinational decode.
  logic [31:0] word_c;
  logic [15:0] pk_c;
  logic [23:0] mant;
  logic [5:0]  p;
  logic [31:0] rem, half;
  logic [7:0]  expo;
  logic signed [7:0] e;
  logic [31:0] ipk;

  always_comb begin
    word_c = '0;
    pk_c = '0;
    mant = '0;
    p = {1'b0, s1_msb};
    rem = '0;
    half = '0;
    e = '0;
    expo = '0;
    ipk = '0;
    if (s1_float) begin
      if (s1_raw[30:23] == 8'hFF) begin
        word_c = '0;
      end else if (s1_raw[30:0] > 31'h3F800000) begin
        word_c = {s1_raw[31], 31'h3F800000};
      end else begin
        word_c = s1_raw;
      end
      pk_c = f32_peak(word_c);
    end else if (s1_frac != 6'd0) begin
      if (s1_mag != 32'd0) begin
        if (s1_msb <= 5'd23) begin
          mant = 24'(s1_mag << (5'd23 - s1_msb));
        end else begin
          mant = 24'(s1_mag >> (s1_msb - 5'd23));
          rem = s1_mag & ((32'd1 << (s1_msb - 5'd23)) - 32'd1);
          half = 32'd1 << (s1_msb - 5'd24);
          if (rem > half || (rem == half && mant[0])) begin
            if (mant == 24'hFFFFFF) begin
              mant = 24'h800000;
              p = p + 6'd1;
            end else begin
              mant = mant + 24'd1;
            end
          end
        end
        e = $signed({2'b00, p}) - $signed({2'b00, s1_frac});
        if (e > 8'sd0 || (e == 8'sd0 && mant[22:0] != 23'd0)) begin
          word_c = {s1_sign, 31'h3F800000};
        end else begin
          expo = 8'(e + 8'sd127);
          word_c = {s1_sign, expo, mant[22:0]};
        end
      end
      pk_c = f32_peak(word_c);
    end else begin
      word_c = s1_wide ? s1_raw : {{16{s1_raw[15]}}, s1_raw[15:0]};
      ipk = s1_wide ? (s1_mag >> 16) : s1_mag;
      pk_c = (ipk > 32'd32768) ? 16'd32768 : ipk[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv1) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_sample <= s1_sample;
      s2_last <= s1_last;
      s2_word <= s1_sample ? word_c : 32'd0;
      s2_pk <= s1_sample ? pk_c : 16'd0;
    end
  end

  // Running peak folds in at the output register.
  logic [15:0] peak_c;
  assign peak_c = (s2_pk > running_peak) ? s2_pk : running_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      running_peak <= '0;
    end else if (adv2) begin
      o_valid <= s2_valid;
      if (s2_valid) begin
        running_peak <= s2_last ? 16'd0 : peak_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_valid) begin
      sample_valid <= s2_sample;
      sample_word <= s2_word;
      peak_level <= peak_c;
      end_of_buffer <= s2_last;
    end
  end

  assign out_valid = o_valid;

endmodule

/* rtl/core/lpcm_sample_unpacker.sv */
// Channel | Dir | Handshake             | Payload
// cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
// in      | in  | in_valid/in_ready     | data_byte, last_byte
// out     | out | out_valid/out_ready   | sample_valid, sample_word, peak_level,
//         |     |                       | end_of_buffer
//
// One byte per cycle sustained unless the output stalls. A byte's result passes
// a queue slot, two decode stages and the output register to reach out_valid.
// rst is synchronous; it clears flags to 12, sample_bits to 16 and the state.
// Output stall backs up through the pipe, then the queue, then in_ready.
// cfg_ready is always high; write only while the block is idle.
module lpcm_sample_unpacker
  import lpcm_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sample_valid,
  output logic [31:0] sample_word,
  output logic [15:0] peak_level,
  output logic        end_of_buffer
);

  logic [31:0] lpcm_flags;
  logic [7:0]  sample_bits;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  lpcm_job_t   fq_job, qb_job;

  assign cfg_ready = 1'b1;

  // Register file: flags word and sample width.
  always_ff @(posedge clk) begin
    if (rst) begin
      lpcm_flags <= FlagsReset;
      sample_bits <= BitsReset;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FLAGS: lpcm_flags <= cfg_data;
        CFG_BITS:  sample_bits <= cfg_data[7:0];
        default:   lpcm_flags <= lpcm_flags;
      endcase
    end
  end

  // Front: gathers bytes, emits a job per complete sample or buffer end.
  lpcm_front u_front (
    .clk, .rst, .lpcm_flags, .sample_bits,
    .in_valid, .in_ready, .data_byte, .last_byte,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  lpcm_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  // Back: decode, peak tracking, output register.
  lpcm_back u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_valid, .out_ready, .sample_valid, .sample_word, .peak_level, .end_of_buffer
  );

endmodule

/* rtl/core/lpcm_checker.sv */
module lpcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        sample_valid,
  input logic [31:0] sample_word,
  input logic [15:0] peak_level,
  input logic        end_of_buffer
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_word))
    else $error("output dropped while stalled");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_level <= 16'd32768)
    else $error("peak out of range");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> sample_word == 32'd0 && end_of_buffer)
    else $error("empty result not a buffer end");

  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !end_of_buffer ##1 out_valid |-> peak_level >= $past(peak_level))
    else $error("peak fell within a buffer");

endmodule

bind lpcm_sample_unpacker lpcm_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .sample_valid, .sample_word, .peak_level,
  .end_of_buffer
);

/* bench/lpcm_sample_unpacker_test.sv */
module lpcm_sample_unpacker_test
  import lpcm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Extra idle wait after the last result arrives, before a config write.
  localparam int DrainCycles = 10;

  // LPCM format flag bits
  localparam logic [31:0] FlagFloat  = 32'h1;
  localparam logic [31:0] FlagBigEnd = 32'h2;
  localparam logic [31:0] FlagSigned = 32'h4;
  localparam logic [31:0] FlagPacked = 32'h8;
  localparam logic [31:0] FlagHigh   = 32'h10;
  localparam logic [31:0] FmtInt     = FlagSigned | FlagPacked;
  localparam logic [31:0] FmtFloat   = FlagFloat | FlagPacked;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_FLAGS;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        sample_valid;
  logic [31:0] sample_word;
  logic [15:0] peak_level;
  logic        end_of_buffer;

  lpcm_sample_unpacker dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .last_byte,
    .out_valid, .out_ready, .sample_valid, .sample_word, .peak_level, .end_of_buffer
  );

  always #1 clk = ~clk;

  typedef struct {
    logic        valid;
    logic [31:0] word;
    logic [15:0] peak;
    logic        eob;
  } pcm_result_t;

  pcm_result_t pending_samples[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  bit          burst_mode = 1'b0;  // no input gaps while set

  // Decoder state mirror
  logic [31:0] fmt_flags = FlagsReset;
  logic [7:0]  fmt_bits = BitsReset;
  logic [1:0]  gather_pos = '0;
  logic [23:0] gather_word = '0;
  logic [15:0] buffer_peak = '0;

  function automatic bit format_valid(logic [31:0] fl, logic [7:0] nbits);
    logic [5:0] frac;
    frac = fl[12:7];
    if ((fl & (FlagBigEnd | FlagHigh)) != 0 || (fl & FlagPacked) == 0) return 1'b0;
    if (fl & FlagFloat) return nbits == 8'd32 && frac == 0;
    if (nbits != 8'd16 && nbits != 8'd32) return 1'b0;
    return (fl & FlagSigned) != 0 && frac < nbits;
  endfunction

  // |x| * 32768, truncated; x is already clamped to [-1,1]
  function automatic logic [15:0] peak_of_float(logic [31:0] w);
    logic [31:0] mant;
    if (w[30:0] >= 31'h3F800000) return 16'h8000;
    if (w[30:23] < 8'd112) return '0;
    mant = {8'd0, 1'b1, w[22:0]};
    mant = mant >> (8'd135 - w[30:23]);
    return mant[15:0];
  endfunction

  // Sign/magnitude integer to float32, RNE, scaled by 2^-frac, clamped to [-1,1]
  function automatic logic [31:0] fixed_to_float(logic s, logic [31:0] m, int frac);
    int          msb;
    int          sh;
    int          ex;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    if (m == 0) return '0;
    msb = 31;
    while (!m[msb]) msb--;
    if (msb <= 23) begin
      mant = m << (23 - msb);
    end else begin
      sh = msb - 23;
      mant = m >> sh;
      rem = m & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        msb++;
      end
    end
    ex = msb - frac;
    if (ex > 0 || (ex == 0 && mant[22:0] != 0)) return {s, 31'h3F800000};
    return {s, 8'(ex + 127), mant[22:0]};
  endfunction

  // Advance the mirror by one accepted byte; queue a result if one is due
  function automatic void decode_byte(logic [7:0] b, logic last);
    pcm_result_t r;
    int          nbytes;
    int          frac;
    logic [31:0] raw;
    logic [31:0] sx;
    logic [31:0] mag;
    logic [31:0] pk;
    r = '{valid: 1'b0, word: '0, peak: '0, eob: 1'b1};
    frac = int'(fmt_flags[12:7]);
    if (!format_valid(fmt_flags, fmt_bits)) begin
      gather_pos = '0;
      gather_word = '0;
      if (last) begin
        r.peak = buffer_peak;
        pending_samples = {pending_samples, r};
        buffer_peak = '0;
      end
      return;
    end
    nbytes = fmt_bits / 8;
    if (gather_pos + 1 >= nbytes) begin
      raw = (nbytes == 2) ? {16'd0, b, gather_word[7:0]} : {b, gather_word};
      if (fmt_flags & FlagFloat) begin
        if (raw[30:23] == 8'hFF) r.word = '0;
        else if (raw[30:0] > 31'h3F800000) r.word = {raw[31], 31'h3F800000};
        else r.word = raw;
        pk = 32'(peak_of_float(r.word));
      end else begin
        sx = (nbytes == 2) ? {{16{raw[15]}}, raw[15:0]} : raw;
        mag = sx[31] ? -sx : sx;
        if (frac != 0) begin
          r.word = fixed_to_float(sx[31], mag, frac);
          pk = 32'(peak_of_float(r.word));
        end else begin
          r.word = sx;
          pk = (nbytes == 2) ? mag : (mag >> 16);
          if (pk > 32768) pk = 32768;
        end
      end
      if (pk > buffer_peak) buffer_peak = pk[15:0];
      gather_pos = '0;
      gather_word = '0;
      r.valid = 1'b1;
      r.peak = buffer_peak;
      r.eob = last;
      pending_samples = {pending_samples, r};
    end else begin
      gather_word = gather_word | (24'(b) << (8 * gather_pos));
      gather_pos = 2'(gather_pos + 1);
      if (last) begin
        r.peak = buffer_peak;
        pending_samples = {pending_samples, r};
      end
    end
    if (last) begin
      gather_pos = '0;
      gather_word = '0;
      buffer_peak = '0;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result word=%h", sample_word);
        fail_count++;
      end else begin
        pcm_result_t r;
        r = pending_samples.pop_front();
        if (sample_valid !== r.valid) begin
          $error("sample_valid exp %0d got %0d", r.valid, sample_valid);
          fail_count++;
        end
        if (sample_word !== r.word) begin
          $error("sample_word exp %h got %h", r.word, sample_word);
          fail_count++;
        end
        if (peak_level !== r.peak) begin
          $error("peak_level exp %0d got %0d", r.peak, peak_level);
          fail_count++;
        end
        if (end_of_buffer !== r.eob) begin
          $error("end_of_buffer exp %0d got %0d", r.eob, end_of_buffer);
          fail_count++;
        end
      end
    end
  end

  // Receiver backpressure: mostly ready, with short stalls and a few long ones
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left <= $urandom_range(1, 3);
        3:       stall_left <= $urandom_range(10, 40);
        default: stall_left <= 0;
      endcase
      out_ready <= 1'b1;
    end
  end

  // One byte transfer, then a random gap unless burst_mode is set
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
    if (burst_mode) return;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3:       gap = $urandom_range(10, 40);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sends a sample little-endian; nb bytes, last on the final one if asked
  task automatic send_sample(logic [31:0] w, int nb, bit last);
    for (int i = 0; i < nb; i++) send_byte(w[8*i +: 8], last && i == nb - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Config write; caller makes sure the block is idle
  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FLAGS) fmt_flags = val;
    else fmt_bits = val[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_format(logic [31:0] fl, logic [7:0] nbits);
    drain();
    write_reg(CFG_FLAGS, fl);
    write_reg(CFG_BITS, {24'd0, nbits});
  endtask

  task automatic test_int16_extremes();
    // reset format: signed packed int16
    send_sample(32'h8000, 2, 0);
    send_sample(32'h7FFF, 2, 0);
    send_sample(32'hFFFF, 2, 0);
    send_byte(8'h5A, 1'b1);   // trailing partial sample dropped
    send_sample(32'h0000, 2, 1);
  endtask

  task automatic test_int32_extremes();
    set_format(FmtInt, 8'd32);
    send_sample(32'h8000_0000, 4, 0);
    send_sample(32'h7FFF_FFFF, 4, 0);
    send_sample(32'h0001_FFFF, 4, 1);
  endtask

  task automatic test_float_special();
    set_format(FmtFloat, 8'd32);
    send_sample(32'h3F80_0000, 4, 0);  // exactly 1.0
    send_sample(32'hC000_0000, 4, 0);  // -2.0 clamps
    send_sample(32'h7FC0_0000, 4, 0);  // NaN -> 0
    send_sample(32'hFF80_0000, 4, 0);  // -inf -> 0
    send_sample(32'h0000_0001, 4, 0);  // denormal
    send_sample(32'h3F00_0000, 4, 1);  // 0.5
  endtask

  task automatic test_fixed_fraction();
    set_format(FmtInt | (32'd15 << FracShift), 8'd16);
    send_sample(32'h8000, 2, 0);
    send_sample(32'h4001, 2, 1);
    set_format(FmtInt | (32'd31 << FracShift), 8'd32);
    send_sample(32'h7FFF_FFFF, 4, 0);  // rounds up to 1.0
    send_sample(32'h0123_4567, 4, 1);
    set_format(FmtInt | (32'd1 << FracShift), 8'd32);
    send_sample(32'h0000_0001, 4, 1);  // exactly 0.5
  endtask

  task automatic test_invalid_formats();
    set_format(32'hFFFF_FFFF, 8'd255);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    set_format(32'h0000_0000, 8'd0);
    send_byte(8'h12, 1'b1);
    set_format(FmtFloat, 8'd16);       // float needs 32 bits
    send_byte(8'h34, 1'b1);
  endtask

  task automatic test_width_change();
    // three bytes gathered as int32, then width shrinks to 16
    set_format(FmtInt, 8'd32);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    set_format(FmtInt, 8'd16);
    send_byte(8'h84, 1'b1);
  endtask

  function automatic logic [31:0] pick_word(int mode);
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000 >> (mode == 0 || mode == 3 ? 16 : 0);
      1:       return $urandom_range(0, 3) - 1;
      2:       return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 130)),
                       23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random();
    int          mode;
    int          nb;
    int          ns;
    logic [31:0] fl;
    logic [7:0]  nbits;
    logic [31:0] junk;
    while (bytes_sent < 1200) begin
      mode = $urandom_range(0, 5);
      // bits 5, 6 and 13 up are ignored by the decoder
      junk = $urandom & 32'hFFFF_E060;
      case (mode)
        0: begin fl = FmtInt; nbits = 8'd16; end
        1: begin fl = FmtInt; nbits = 8'd32; end
        2: begin fl = FmtFloat; nbits = 8'd32; end
        3: begin fl = FmtInt | ($urandom_range(1, 15) << FracShift); nbits = 8'd16; end
        4: begin fl = FmtInt | ($urandom_range(1, 31) << FracShift); nbits = 8'd32; end
        default: begin
          fl = $urandom;
          nbits = $urandom_range(0, 1) ? 8'($urandom) : 8'(16 << $urandom_range(0, 1));
        end
      endcase
      if ($urandom_range(0, 1)) fl = fl | junk;
      set_format(fl, nbits);
      burst_mode = $urandom_range(0, 3) == 0;
      nb = (nbits == 8'd32) ? 4 : 2;
      repeat ($urandom_range(1, 4)) begin
        ns = $urandom_range(0, 6);
        repeat (ns) send_sample(pick_word(mode), nb, 1'b0);
        // final sample whole or cut short
        send_sample(pick_word(mode), $urandom_range(1, nb), 1'b1);
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_int16_extremes();
    test_int32_extremes();
    test_float_special();
    test_fixed_fraction();
    test_invalid_formats();
    test_width_change();
    test_random();
    drain();
    if (pending_samples.size() != 0) begin
      $error("%0d results never arrived", pending_samples.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/lpcm_pkg.sv
rtl/core/lpcm_front.sv
rtl/core/lpcm_queue.sv
rtl/core/lpcm_back.sv
rtl/core/lpcm_sample_unpacker.sv
rtl/core/lpcm_checker.sv
bench/lpcm_sample_unpacker_test.sv
